/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Condition must hold at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);
// Antecedent at one edge implies consequent at the next edge, reset included.
`define ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_NEXT(lbl, clk, ante, cons, msg)
`endif

`endif

/* hdl/lcdnw_pkg.sv */
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Types, codes and constant tables of the character LCD nibble writer.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

    // Request codes carried on s_tuser
    typedef enum logic [2:0] {
        OP_INIT   = 3'd0,
        OP_CMD    = 3'd1,
        OP_CHAR   = 3'd2,
        OP_CURSOR = 3'd3,
        OP_NUMBER = 3'd4
    } op_t;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_PULSE     = 3'd0,
        REG_INIT_GAP  = 3'd1,
        REG_SETTLE    = 3'd2,
        REG_CHAR_GAP  = 3'd3,
        REG_CURSOR    = 3'd4
    } reg_idx_t;

    // Work kinds handed from front to back
    typedef enum logic [1:0] {
        JOB_INIT = 2'd0,
        JOB_BYTE = 2'd1,
        JOB_NUM  = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic        rs;      // register select for byte jobs
        logic [7:0]  data;    // byte for byte jobs
        logic [1:0]  ndig;    // digit count for number jobs (1..3)
        logic [3:0]  dig0;    // digits in emission order, most significant first
        logic [3:0]  dig1;
        logic [3:0]  dig2;
    } job_t;

    typedef struct packed {
        logic [7:0] init_gap_ms;
        logic [7:0] settle_ms;
        logic [7:0] char_gap_ms;
    } wait_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam int          INIT_LEN      = 9;
    localparam int          INIT_GAP_CNT  = 3;
    localparam logic [4:0]  INIT_NIBBLES  = 5'(2 * INIT_LEN);
    localparam logic [4:0]  BYTE_NIBBLES  = 5'd2;
    localparam logic [7:0]  ASCII_ZERO    = 8'h30;

    localparam logic [7:0] RST_PULSE    = 8'd1;
    localparam logic [7:0] RST_INIT_GAP = 8'd4;
    localparam logic [7:0] RST_SETTLE   = 8'd20;
    localparam logic [7:0] RST_CHAR_GAP = 8'd2;
    localparam logic [7:0] RST_CURSOR   = 8'h80;

    // Power-up command sequence
    function automatic logic [7:0] init_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h03;
            4'd1:    b = 8'h03;
            4'd2:    b = 8'h03;
            4'd3:    b = 8'h02;
            4'd4:    b = 8'h28;
            4'd5:    b = 8'h08;
            4'd6:    b = 8'h01;
            4'd7:    b = 8'h06;
            4'd8:    b = 8'h0c;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // DDRAM start address of each display row
    function automatic logic [7:0] row_offset(input logic [1:0] row);
        logic [7:0] o;
        case (row)
            2'd0:    o = 8'h00;
            2'd1:    o = 8'h40;
            2'd2:    o = 8'h10;
            default: o = 8'h50;
        endcase
        return o;
    endfunction

endpackage

/* hdl/lcdnw_front.sv */
// ----------------------------------------------------------------------------
// lcdnw_front
// Classifies an incoming request word into a job for the back sequencer.
// ----------------------------------------------------------------------------
module lcdnw_front (
    input  logic [2:0]          op,
    input  logic [7:0]          value,
    input  logic [1:0]          row,
    input  logic [3:0]          column,
    input  logic [7:0]          cursor_command,
    output logic                job_valid,
    output lcdnw_pkg::job_t     job
);
    import lcdnw_pkg::*;

    logic [15:0] q_prod;
    logic [4:0]  quot;      // value / 10
    logic [12:0] h_prod;
    logic [1:0]  hund;      // value / 100
    logic [3:0]  ones;
    logic [3:0]  tens;
    logic [7:0]  cur_addr;

    // Divide by ten through a reciprocal; exact for 8-bit inputs
    assign q_prod = {8'd0, value} * 16'd205;
    assign quot   = q_prod[15:11];
    assign h_prod = {8'd0, quot} * 13'd205;
    assign hund   = h_prod[12:11];
    assign ones   = 4'(value - {3'd0, quot} * 8'd10);
    assign tens   = 4'(quot - {3'd0, hund} * 5'd10);

    assign cur_addr = {4'd0, column} + row_offset(row);

    always_comb begin
        job       = '0;
        job.kind  = JOB_BYTE;
        job_valid = 1'b1;
        case (op)
            OP_INIT: begin
                job.kind = JOB_INIT;
            end
            OP_CMD: begin
                job.data = value;
            end
            OP_CHAR: begin
                job.rs   = 1'b1;
                job.data = value;
            end
            OP_CURSOR: begin
                job.data = cur_addr | cursor_command;
            end
            OP_NUMBER: begin
                job.kind = JOB_NUM;
                job.rs   = 1'b1;
                if (value >= 8'd100) begin
                    job.ndig = 2'd3;
                    job.dig0 = {2'b00, hund};
                    job.dig1 = tens;
                    job.dig2 = ones;
                end else if (value >= 8'd10) begin
                    job.ndig = 2'd2;
                    job.dig0 = tens;
                    job.dig1 = ones;
                end else begin
                    job.ndig = 2'd1;
                    job.dig0 = ones;
                end
            end
            default: begin
                // drop unknown requests
                job_valid = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/lcdnw_queue.sv */
// ----------------------------------------------------------------------------
// lcdnw_queue
// Small job FIFO between the front classifier and the back sequencer.
// ----------------------------------------------------------------------------
module lcdnw_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lcdnw_pkg::job_t     push_job,
    input  logic                pop,
    output lcdnw_pkg::job_t     head_job,
    output lcdnw_pkg::q_stat_t  stat
);
    import lcdnw_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hdl/lcdnw_back.sv */
// ----------------------------------------------------------------------------
// lcdnw_back
// Job sequencer: expands one job into nibble words, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module lcdnw_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lcdnw_pkg::wait_cfg_t wait_cfg,
    input  lcdnw_pkg::job_t      head_job,
    input  logic                 q_empty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_rs,
    output logic [3:0]           out_nibble,
    output logic [7:0]           out_wait,
    output logic                 out_last
);
    import lcdnw_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t      state_reg, state_next;
    job_t        job_reg, job_next;
    logic [4:0]  step_reg, step_next;
    logic        valid_reg, valid_next;
    logic        rs_reg, rs_next;
    logic [3:0]  nib_reg, nib_next;
    logic [7:0]  wait_reg, wait_next;
    logic        last_reg, last_next;

    logic        out_free;
    logic [3:0]  byte_idx;
    logic        low_half;
    logic [7:0]  cur_byte;
    logic [7:0]  cur_wait;
    logic [4:0]  last_step;
    logic [3:0]  cur_digit;

    assign out_free = !valid_reg || out_ready;
    assign byte_idx = step_reg[4:1];
    assign low_half = step_reg[0];

    always_comb begin
        case (byte_idx[1:0])
            2'd0:    cur_digit = job_reg.dig0;
            2'd1:    cur_digit = job_reg.dig1;
            default: cur_digit = job_reg.dig2;
        endcase
    end

    always_comb begin
        cur_byte  = job_reg.data;
        cur_wait  = '0;
        last_step = BYTE_NIBBLES - 1'b1;
        case (job_reg.kind)
            JOB_INIT: begin
                cur_byte  = init_byte(byte_idx);
                last_step = INIT_NIBBLES - 1'b1;
                if (byte_idx < 4'(INIT_GAP_CNT)) begin
                    cur_wait = wait_cfg.init_gap_ms;
                end else if (byte_idx == 4'(INIT_LEN - 1)) begin
                    cur_wait = wait_cfg.settle_ms;
                end
            end
            JOB_NUM: begin
                cur_byte  = ASCII_ZERO | {4'd0, cur_digit};
                cur_wait  = wait_cfg.char_gap_ms;
                last_step = {2'b00, job_reg.ndig, 1'b0} - 1'b1;
            end
            default: begin
                cur_byte = job_reg.data;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        step_next  = step_reg;
        valid_next = valid_reg && !out_ready;
        rs_next    = rs_reg;
        nib_next   = nib_reg;
        wait_next  = wait_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    pop        = 1'b1;
                    job_next   = head_job;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    rs_next    = job_reg.rs;
                    nib_next   = low_half ? cur_byte[3:0] : cur_byte[7:4];
                    wait_next  = low_half ? cur_wait : 8'd0;
                    last_next  = (step_reg == last_step);
                    if (step_reg == last_step) begin
                        state_next = ST_IDLE;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            job_reg   <= job_next;
            step_reg  <= step_next;
            rs_reg    <= rs_next;
            nib_reg   <= nib_next;
            wait_reg  <= wait_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_rs     = rs_reg;
    assign out_nibble = nib_reg;
    assign out_wait   = wait_reg;
    assign out_last   = last_reg;

endmodule

/* hdl/char_lcd_nibble_writer_top.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_top
// Character LCD 4-bit bus writer: requests in, nibble transfer words out.
// ----------------------------------------------------------------------------
// Each request word (init, command, character, cursor move or decimal number)
// becomes a run of nibble words for an HD44780-style 4-bit bus, high nibble
// first, with m_tlast on the final nibble of the request. A front classifier
// turns the request into a job (cursor address and decimal digits are worked
// out here) and drops unknown request codes; a QUEUE_DEPTH-entry job queue
// decouples it from the back sequencer, which emits one nibble word per cycle
// into an output register unless the output stalls. The sequencer pops a job
// from the queue while idle, then steps through its nibbles and returns to
// idle after the last one. Requests are taken while the queue has room, so a
// new request can arrive while earlier nibbles drain. Configuration lives in
// five 8-bit registers at byte addresses 0x00..0x10 and is to be written only
// while no request is in flight. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module char_lcd_nibble_writer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // value[7:0], row[9:8], column[13:10], zero pad
    input  logic [2:0]  s_tuser,   // op[2:0]
    // nibble channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // nibble[3:0], wait_after_ms[11:4], zero pad
    output logic        m_tuser,   // reg_select[0]
    output logic        m_tlast,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lcdnw_pkg::*;

    logic [7:0] pulse_ms_reg;
    logic [7:0] init_gap_ms_reg;
    logic [7:0] settle_ms_reg;
    logic [7:0] char_gap_ms_reg;
    logic [7:0] cursor_command_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    logic       job_valid;
    job_t       front_job;
    job_t       head_job;
    q_stat_t    q_stat;
    logic       q_pop;
    logic       s_accept;
    wait_cfg_t  wait_cfg;

    logic       out_rs;
    logic [3:0] out_nibble;
    logic [7:0] out_wait;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_ms_reg       <= RST_PULSE;
            init_gap_ms_reg    <= RST_INIT_GAP;
            settle_ms_reg      <= RST_SETTLE;
            char_gap_ms_reg    <= RST_CHAR_GAP;
            cursor_command_reg <= RST_CURSOR;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PULSE:    pulse_ms_reg       <= pwdata[7:0];
                REG_INIT_GAP: init_gap_ms_reg    <= pwdata[7:0];
                REG_SETTLE:   settle_ms_reg      <= pwdata[7:0];
                REG_CHAR_GAP: char_gap_ms_reg    <= pwdata[7:0];
                REG_CURSOR:   cursor_command_reg <= pwdata[7:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // Readback; pulse_ms only paces the bus and never shows in a nibble word
    always_comb begin
        case (cfg_idx)
            REG_PULSE:    prdata = {24'd0, pulse_ms_reg};
            REG_INIT_GAP: prdata = {24'd0, init_gap_ms_reg};
            REG_SETTLE:   prdata = {24'd0, settle_ms_reg};
            REG_CHAR_GAP: prdata = {24'd0, char_gap_ms_reg};
            REG_CURSOR:   prdata = {24'd0, cursor_command_reg};
            default:      prdata = '0;
        endcase
    end

    assign wait_cfg.init_gap_ms = init_gap_ms_reg;
    assign wait_cfg.settle_ms   = settle_ms_reg;
    assign wait_cfg.char_gap_ms = char_gap_ms_reg;

    // ---------------- front: classify ----------------
    // Accept whenever the queue has room; unknown codes are swallowed.
    assign s_tready = !q_stat.full;
    assign s_accept = s_tvalid && s_tready;

    lcdnw_front u_front (
        .op             (s_tuser),
        .value          (s_tdata[7:0]),
        .row            (s_tdata[9:8]),
        .column         (s_tdata[13:10]),
        .cursor_command (cursor_command_reg),
        .job_valid      (job_valid),
        .job            (front_job)
    );

    // ---------------- job queue ----------------
    lcdnw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_accept && job_valid),
        .push_job (front_job),
        .pop      (q_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    // ---------------- back: nibble sequencer ----------------
    lcdnw_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wait_cfg   (wait_cfg),
        .head_job   (head_job),
        .q_empty    (q_stat.empty),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rs     (out_rs),
        .out_nibble (out_nibble),
        .out_wait   (out_wait),
        .out_last   (m_tlast)
    );

    assign m_tdata = {4'd0, out_wait, out_nibble};
    assign m_tuser = out_rs;

    // ---------------- checks ----------------
    `ASSERT_ALWAYS(a_q_full_empty, aclk, aresetn, !(q_stat.full && q_stat.empty), "queue full and empty at once")
    `ASSERT_NEXT(a_rst_out_idle, aclk, !aresetn, !m_tvalid, "nibble word valid right after reset")
    `ASSERT_ALWAYS(a_pop_nonempty, aclk, aresetn, !(q_pop && q_stat.empty), "sequencer pops an empty queue")

endmodule

/* verif/char_lcd_nibble_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_checker
// Watches the request, nibble and register channels of the LCD nibble writer.
// ----------------------------------------------------------------------------
// Keeps its own copy of the wait and cursor registers from observed writes,
// expands every accepted request into the nibble words the bus must carry,
// and compares each accepted nibble word with the oldest one still owed.
// ----------------------------------------------------------------------------
module char_lcd_nibble_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // value[7:0], row[9:8], column[13:10], zero pad
    input  logic [2:0]  s_tuser,   // op[2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // nibble[3:0], wait_after_ms[11:4], zero pad
    input  logic        m_tuser,   // reg_select[0]
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int unsigned mismatch_count,
    output int unsigned words_owed
);
    import lcdnw_pkg::*;

    typedef struct packed {
        logic       rs;
        logic [3:0] nib;
        logic [7:0] wait_ms;
        logic       last;
    } nibble_word_t;

    // Power-up commands, first one in the low byte
    localparam int          POWER_UP_LEN  = 9;
    localparam logic [71:0] POWER_UP_CMDS = 72'h0c_06_01_08_28_02_03_03_03;
    // DDRAM base of rows 0..3, row 0 in the low byte
    localparam logic [31:0] ROW_BASE      = 32'h50_10_40_00;
    localparam logic [7:0]  CHAR_ZERO     = 8'h30;
    localparam int          SHOWN_LIMIT   = 10;

    logic [7:0] init_gap_ms;
    logic [7:0] settle_ms;
    logic [7:0] char_gap_ms;
    logic [7:0] cursor_cmd;

    nibble_word_t owed_words[$];

    // High nibble carries no wait and never closes the request
    function automatic void owe_byte(logic rs, logic [7:0] b, logic [7:0] wait_ms,
                                     logic last);
        owed_words.push_back({rs, b[7:4], 8'h00, 1'b0});
        owed_words.push_back({rs, b[3:0], wait_ms, last});
    endfunction

    function automatic void expand_request(logic [2:0] op, logic [7:0] value,
                                           logic [1:0] row, logic [3:0] column);
        logic [7:0] addr;
        logic [7:0] gap;
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
        case (op)
            OP_INIT: begin
                for (int c = 0; c < POWER_UP_LEN; c++) begin
                    gap = (c < 3) ? init_gap_ms : (c == POWER_UP_LEN - 1) ? settle_ms : 8'h00;
                    owe_byte(1'b0, POWER_UP_CMDS[8*c +: 8], gap, c == POWER_UP_LEN - 1);
                end
            end
            OP_CMD:  owe_byte(1'b0, value, 8'h00, 1'b1);
            OP_CHAR: owe_byte(1'b1, value, 8'h00, 1'b1);
            OP_CURSOR: begin
                addr = ({4'h0, column} + ROW_BASE[8*row +: 8]) | cursor_cmd;
                owe_byte(1'b0, addr, 8'h00, 1'b1);
            end
            OP_NUMBER: begin
                hundreds = 4'(value / 100);
                tens     = 4'((value / 10) % 10);
                ones     = 4'(value % 10);
                // suppress leading zeros, but always show the units digit
                if (hundreds != 0)
                    owe_byte(1'b1, CHAR_ZERO + hundreds, char_gap_ms, 1'b0);
                if (hundreds != 0 || tens != 0)
                    owe_byte(1'b1, CHAR_ZERO + tens, char_gap_ms, 1'b0);
                owe_byte(1'b1, CHAR_ZERO + ones, char_gap_ms, 1'b1);
            end
            default: ;  // unknown codes produce nothing
        endcase
    endfunction

    function automatic void check_word(nibble_word_t got);
        nibble_word_t want;
        if (owed_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_LIMIT)
                $display("%0t: nibble word with nothing owed: %s%0b %s%h %s%0d %s%0b",
                         $realtime, "rs=", got.rs, "nib=", got.nib,
                         "wait=", got.wait_ms, "last=", got.last);
        end else begin
            want = owed_words.pop_front();
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_LIMIT)
                    $display({"%0t: nibble word mismatch: ",
                              "expected rs=%0b nib=%h wait=%0d last=%0b, ",
                              "got rs=%0b nib=%h wait=%0d last=%0b"},
                             $realtime, want.rs, want.nib, want.wait_ms, want.last,
                             got.rs, got.nib, got.wait_ms, got.last);
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            init_gap_ms    = 8'd4;
            settle_ms      = 8'd20;
            char_gap_ms    = 8'd2;
            cursor_cmd     = 8'h80;
            mismatch_count = 0;
            owed_words.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_PULSE:    ;  // paces the bus only, never in a word
                    REG_INIT_GAP: init_gap_ms = pwdata[7:0];
                    REG_SETTLE:   settle_ms   = pwdata[7:0];
                    REG_CHAR_GAP: char_gap_ms = pwdata[7:0];
                    REG_CURSOR:   cursor_cmd  = pwdata[7:0];
                    default: ;  // past the register list
                endcase
            end
            if (s_tvalid && s_tready)
                expand_request(s_tuser, s_tdata[7:0], s_tdata[9:8], s_tdata[13:10]);
            if (m_tvalid && m_tready)
                check_word({m_tuser, m_tdata[3:0], m_tdata[11:4], m_tlast});
        end
        words_owed = owed_words.size();
    end

endmodule

/* verif/tb_char_lcd_nibble_writer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_writer_top
// Stimulus and verdict for the character LCD nibble writer.
// ----------------------------------------------------------------------------
// Drives a short directed set of requests (every op, field extremes, number
// edge cases, unknown op codes), then random request phases under several
// register settings, minimum and maximum among them. Both stream sides idle
// at random with burst stretches. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_writer_top;
    import lcdnw_pkg::*;

    localparam logic [2:0] OP_CODE_MAX   = 3'd7;
    localparam int         PHASES        = 5;
    localparam int         PHASE_ITEMS   = 56;
    // covers an init job in the back end plus two queued jobs and the front
    localparam int         SETTLE_CYCLES = 48;
    localparam int         CYCLE_LIMIT   = 600000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'h0000;   // value[7:0], row[9:8], column[13:10], zero pad
    logic [2:0]  s_tuser  = 3'd0;       // op[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;               // nibble[3:0], wait_after_ms[11:4], zero pad
    logic        m_tuser;               // reg_select[0]
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = 5'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned mismatch_count;
    int unsigned words_owed;
    int unsigned cycle_count = 0;

    // Burst flags switch idling off for stretches of words
    bit          src_burst  = 1'b0;
    bit          sink_burst = 1'b0;
    int unsigned sink_hold  = 0;

    always #10 aclk = ~aclk;

    char_lcd_nibble_writer_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    char_lcd_nibble_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .words_owed     (words_owed)
    );

    // Count cycles; the watcher below ends a hung run
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Nibble sink: after each taken word, tready may drop for a random stall; bursts never stall
    always @(posedge aclk) begin : sink_ctl
        int unsigned stall;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= (sink_hold == 1);
        end else if (m_tready && m_tvalid) begin
            if ($urandom_range(0, 29) == 0)
                sink_burst <= !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 17);
            sink_hold <= stall;
            m_tready  <= (stall == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Present one request word and hold it until the block takes it
    task automatic send_request(logic [2:0] op, logic [7:0] value, logic [1:0] row,
                                logic [3:0] column);
        int unsigned gap;
        if ($urandom_range(0, 24) == 0)
            src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, column, row, value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic random_request(output bit counted);
        int unsigned pick;
        logic [2:0]  op;
        logic [7:0]  value;
        pick    = $urandom_range(0, 99);
        value   = 8'($urandom_range(0, 255));
        counted = 1'b1;
        if (pick < 6) begin
            op = OP_INIT;
        end else if (pick < 26) begin
            op = OP_CMD;
        end else if (pick < 46) begin
            op = OP_CHAR;
        end else if (pick < 66) begin
            op = OP_CURSOR;
        end else if (pick < 94) begin
            op = OP_NUMBER;
            // spread numbers evenly over one, two and three digits
            case ($urandom_range(0, 2))
                0:       value = 8'($urandom_range(0, 9));
                1:       value = 8'($urandom_range(10, 99));
                default: value = 8'($urandom_range(100, 255));
            endcase
        end else begin
            op      = 3'($urandom_range(OP_NUMBER + 1, OP_CODE_MAX));
            counted = 1'b0;
        end
        send_request(op, value, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
    endtask

    // Drop valid, wait until every owed word is out, then let the pipe empty
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_owed != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; done at the edge where pready is seen
    task automatic cfg_write(logic [4:0] addr, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        // upper bits are junk on purpose: only the low byte is kept
        pwdata  <= {24'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(logic [7:0] pulse, logic [7:0] init_gap,
                                  logic [7:0] settle, logic [7:0] char_gap,
                                  logic [7:0] cursor);
        cfg_write({REG_PULSE,    2'b00}, pulse);
        cfg_write({REG_INIT_GAP, 2'b00}, init_gap);
        cfg_write({REG_SETTLE,   2'b00}, settle);
        cfg_write({REG_CHAR_GAP, 2'b00}, char_gap);
        cfg_write({REG_CURSOR,   2'b00}, cursor);
    endtask

    initial begin
        int unsigned known;
        bit          counted;
        logic [2:0]  stray_idx;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words under reset settings
        send_request(OP_INIT,   8'h00, 2'd0, 4'd0);
        send_request(OP_CMD,    8'h00, 2'd3, 4'd15);
        send_request(OP_CMD,    8'hff, 2'd0, 4'd0);
        send_request(OP_CHAR,   8'h00, 2'd0, 4'd0);
        send_request(OP_CHAR,   8'hff, 2'd3, 4'd15);
        send_request(OP_CHAR,   8'h5a, 2'd1, 4'd10);
        // every row base, column extremes
        send_request(OP_CURSOR, 8'h00, 2'd0, 4'd0);
        send_request(OP_CURSOR, 8'hff, 2'd1, 4'd15);
        send_request(OP_CURSOR, 8'h00, 2'd2, 4'd5);
        send_request(OP_CURSOR, 8'h00, 2'd3, 4'd15);
        send_request(OP_CURSOR, 8'h00, 2'd3, 4'd0);
        // zero shows as one digit; digit-count boundaries
        send_request(OP_NUMBER, 8'd0,   2'd0, 4'd0);
        send_request(OP_NUMBER, 8'd7,   2'd0, 4'd0);
        send_request(OP_NUMBER, 8'd10,  2'd0, 4'd0);
        send_request(OP_NUMBER, 8'd99,  2'd0, 4'd0);
        send_request(OP_NUMBER, 8'd100, 2'd0, 4'd0);
        send_request(OP_NUMBER, 8'd199, 2'd0, 4'd0);
        send_request(OP_NUMBER, 8'd255, 2'd3, 4'd15);
        // unknown codes must vanish without a word
        send_request(3'(OP_NUMBER + 1), 8'h12, 2'd1, 4'd3);
        send_request(3'(OP_NUMBER + 2), 8'hff, 2'd3, 4'd15);
        send_request(OP_CODE_MAX,   8'h00, 2'd0, 4'd0);
        send_request(OP_INIT,   8'hff, 2'd3, 4'd15);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                drain();
                case (phase)
                    1: apply_settings(8'd1, 8'd0, 8'd0, 8'd0, 8'h00);
                    2: apply_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'hff);
                    3: begin
                        apply_settings(8'($urandom_range(1, 255)),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)));
                        // a write past the register list must change nothing
                        stray_idx = 3'($urandom_range(REG_CURSOR + 1, 7));
                        cfg_write({stray_idx, 2'b00}, 8'($urandom_range(0, 255)));
                    end
                    default: apply_settings(8'($urandom_range(1, 255)),
                                            8'($urandom_range(0, 255)),
                                            8'($urandom_range(0, 255)),
                                            8'($urandom_range(0, 255)),
                                            8'($urandom_range(0, 255)));
                endcase
            end
            known = 0;
            while (known < PHASE_ITEMS) begin
                random_request(counted);
                if (counted)
                    known++;
            end
        end

        drain();
        if (mismatch_count == 0 && words_owed == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/lcdnw_pkg.sv
hdl/lcdnw_front.sv
hdl/lcdnw_queue.sv
hdl/lcdnw_back.sv
hdl/char_lcd_nibble_writer_top.sv
verif/char_lcd_nibble_checker.sv
verif/tb_char_lcd_nibble_writer_top.sv
